// ----- sv/diff_drive_odometry_defines.svh -----
// assertion macros used by the checker file
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// consequent checked in the same cycle
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ddo_pkg.sv -----
package ddo_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 48;
   localparam int CNT_W     = 32;
   localparam int ANG_W     = 32;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W     = CNT_W + 1;
   localparam int DEG_W     = 25;
   localparam int DEG_SHIFT = 16;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // travel scaling and cordic datapath width
   localparam int SH = 31 - FRAC_BITS;
   localparam int CW = 65 - SH;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W = $clog2(CORDIC_STEPS);

   localparam logic [MUL_B_W-1:0] KGAIN_Q30  = 32'd652032874;
   localparam logic [MUL_B_W-1:0] DEG_SCALE  = 32'd360;
   localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(1) << (SH - 1);

   // millimetre product split into two partial products
   localparam int MM_SPLIT = POS_W / 2;
   localparam int ACC_W    = POS_W + CFG_W + 1;
   localparam logic [ACC_W-1:0] MM_POS_LIMIT = (ACC_W'(1) << (POS_W - 1)) - ACC_W'(1);
   localparam logic [ACC_W-1:0] MM_NEG_LIMIT = ACC_W'(1) << (POS_W - 1);

   localparam logic [DEG_W-1:0] DEG_LIMIT = 25'd23592960;
   localparam logic [CFG_W-1:0] MM_PER_TICK_RESET = 32'd65536;

   localparam logic [CSR_IDX_W-1:0] REG_START_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_PER_TICK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MM_PER_TICK   = 3'd4;

   localparam logic CMD_INIT   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TURN,
      ST_GAIN,
      ST_ROT_LOAD,
      ST_ROT,
      ST_POS,
      ST_MM_LO,
      ST_MM_HI,
      ST_MM_SUM,
      ST_MM_SAT,
      ST_DEG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
   } rot_ctrl_type;

   function automatic logic [ANG_W-1:0] atan_angle(input logic [STEP_W-1:0] step);
      logic [ANG_W-1:0] a;
      case (step)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- sv/ddo_req_if.sv -----
interface ddo_req_if;
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic signed [ddo_pkg::CNT_W-1:0]   left_count;
   logic signed [ddo_pkg::CNT_W-1:0]   right_count;

   modport source (output valid, command, left_count, right_count, input ready);
   modport sink   (input valid, command, left_count, right_count, output ready);
endinterface

// ----- sv/ddo_rsp_if.sv -----
interface ddo_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ddo_pkg::POS_W-1:0]   raw_x;
   logic signed [ddo_pkg::POS_W-1:0]   raw_y;
   logic        [ddo_pkg::ANG_W-1:0]   raw_heading;
   logic signed [ddo_pkg::POS_W-1:0]   x_mm;
   logic signed [ddo_pkg::POS_W-1:0]   y_mm;
   logic        [ddo_pkg::DEG_W-1:0]   heading_deg;

   modport source (output valid, raw_x, raw_y, raw_heading, x_mm, y_mm, heading_deg,
                   input ready);
   modport sink   (input valid, raw_x, raw_y, raw_heading, x_mm, y_mm, heading_deg,
                   output ready);
endinterface

// ----- sv/ddo_mul.sv -----
module ddo_mul (
   input  logic                        clock,
   input  logic [ddo_pkg::MUL_A_W-1:0] mul_a,
   input  logic [ddo_pkg::MUL_B_W-1:0] mul_b,
   output logic [ddo_pkg::MUL_P_W-1:0] mul_p
);

   logic [ddo_pkg::MUL_P_W-1:0] prod_ff;
   logic [ddo_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = ddo_pkg::MUL_P_W'(mul_a) * ddo_pkg::MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// ----- sv/ddo_cordic.sv -----
module ddo_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  ddo_pkg::rot_ctrl_type         rot_ctrl,
   input  logic signed [ddo_pkg::CW-1:0] rot_t,
   input  logic [ddo_pkg::ANG_W-1:0]     rot_angle,
   output logic signed [ddo_pkg::CW-1:0] rot_x,
   output logic signed [ddo_pkg::CW-1:0] rot_y,
   output logic                          rot_last
);

   logic signed [ddo_pkg::CW-1:0]    x_ff, x_in;
   logic signed [ddo_pkg::CW-1:0]    y_ff, y_in;
   logic signed [ddo_pkg::ANG_W-1:0] z_ff, z_in;
   logic [ddo_pkg::STEP_W-1:0]       step_ff, step_in;
   logic signed [ddo_pkg::CW-1:0]    xs, ys;
   logic signed [ddo_pkg::ANG_W-1:0] a_step;

   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign a_step = $signed(ddo_pkg::atan_angle(step_ff));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      if (rot_ctrl.load) begin
         // quadrant from the top two angle bits
         case (rot_angle[ddo_pkg::ANG_W-1 -: 2])
            2'd0: begin
               x_in = rot_t;
               y_in = '0;
            end
            2'd1: begin
               x_in = '0;
               y_in = rot_t;
            end
            2'd2: begin
               x_in = -rot_t;
               y_in = '0;
            end
            default: begin
               x_in = '0;
               y_in = -rot_t;
            end
         endcase
         z_in    = $signed({2'b00, rot_angle[ddo_pkg::ANG_W-3:0]});
         step_in = '0;
      end else if (rot_ctrl.run) begin
         if (!z_ff[ddo_pkg::ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - a_step;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + a_step;
         end
         step_in = step_ff + ddo_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign rot_x    = x_ff;
   assign rot_y    = y_ff;
   assign rot_last = (step_ff == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1));

endmodule

// ----- sv/diff_drive_odometry.sv -----
// differential drive odometry, midpoint heading
// req_ch carries a command with absolute left and right encoder counts; a
// transfer happens on a clock edge with valid and ready both high. command
// init loads the start pose from the csr registers and takes the counts as
// reference; command update advances the pose from the count deltas.
// rsp_ch returns one result per request: the raw pose and the pose in
// millimetres and degrees after that request.
// csr_write_enable writes csr_write_data into register csr_index on the
// clock edge; write only while no request is in flight.
// an update runs the turn and gain products, the 30 cordic iterations on one
// shift-add unit, the position step and the millimetre and degree steps; an
// init goes straight to the millimetre and degree steps. all products use
// one shared 33x32 multiplier.
// req_ch.ready is high only while the sequencer is idle, so one request is
// in flight at a time; the next may be taken while the result waits.
// if the receiver stalls, the result is held in the output register and the
// sequencer waits at its last step until that register frees up.
// synchronous reset clears the pose, the references, the registers to their
// defaults and drops rsp_ch.valid.
module diff_drive_odometry (
   input  logic                            clock,
   input  logic                            reset,
   ddo_req_if.sink                         req_ch,
   ddo_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ddo_pkg::CFG_W-1:0]       csr_write_data
);

   ddo_pkg::state_type state_ff, state_in;

   logic [ddo_pkg::CFG_W-1:0] start_x_ff, start_x_in;
   logic [ddo_pkg::CFG_W-1:0] start_y_ff, start_y_in;
   logic [ddo_pkg::CFG_W-1:0] start_heading_ff, start_heading_in;
   logic [ddo_pkg::CFG_W-1:0] turn_per_tick_ff, turn_per_tick_in;
   logic [ddo_pkg::CFG_W-1:0] mm_per_tick_ff, mm_per_tick_in;

   logic [ddo_pkg::POS_W-1:0] pos_x_ff, pos_x_in;
   logic [ddo_pkg::POS_W-1:0] pos_y_ff, pos_y_in;
   logic [ddo_pkg::ANG_W-1:0] heading_ff, heading_in;
   logic [ddo_pkg::CNT_W-1:0] prev_left_ff, prev_left_in;
   logic [ddo_pkg::CNT_W-1:0] prev_right_ff, prev_right_in;

   logic [ddo_pkg::CNT_W-1:0] diff_ff, diff_in;
   logic [ddo_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [ddo_pkg::ANG_W-1:0] mid_ff, mid_in;
   logic                      axis_ff, axis_in;
   logic                      neg_ff, neg_in;
   logic [ddo_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [ddo_pkg::POS_W-1:0] x_mm_ff, x_mm_in;
   logic [ddo_pkg::POS_W-1:0] y_mm_ff, y_mm_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ddo_pkg::POS_W-1:0] rsp_raw_x_ff, rsp_raw_y_ff;
   logic [ddo_pkg::ANG_W-1:0] rsp_raw_heading_ff;
   logic [ddo_pkg::POS_W-1:0] rsp_x_mm_ff, rsp_y_mm_ff;
   logic [ddo_pkg::DEG_W-1:0] rsp_heading_deg_ff;

   logic                        req_ready;
   logic                        req_xfer;
   logic                        rsp_free;
   logic                        rsp_load;
   logic [ddo_pkg::MUL_A_W-1:0] mul_a;
   logic [ddo_pkg::MUL_B_W-1:0] mul_b;
   logic [ddo_pkg::MUL_P_W-1:0] mul_p;
   ddo_pkg::rot_ctrl_type       rot_ctrl;
   logic signed [ddo_pkg::CW-1:0] rot_t;
   logic signed [ddo_pkg::CW-1:0] rot_x, rot_y;
   logic                        rot_last;

   logic [ddo_pkg::CNT_W-1:0] delta_l, delta_r;
   logic [ddo_pkg::SUM_W-1:0] travel_mag;
   logic [ddo_pkg::CW-1:0]    t_mag;
   logic [ddo_pkg::ANG_W-1:0] dturn;
   logic [ddo_pkg::POS_W-1:0] pos_sel, pos_mag;
   logic [ddo_pkg::ACC_W-1:0] mm_res, mm_limit, mm_clip;
   logic [ddo_pkg::POS_W-1:0] mm_val;

   ddo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ddo_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .rot_ctrl  (rot_ctrl),
      .rot_t     (rot_t),
      .rot_angle (mid_ff),
      .rot_x     (rot_x),
      .rot_y     (rot_y),
      .rot_last  (rot_last)
   );

   assign req_xfer = req_ch.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign delta_l    = $unsigned(req_ch.left_count) - prev_left_ff;
   assign delta_r    = $unsigned(req_ch.right_count) - prev_right_ff;
   assign travel_mag = sum_ff[ddo_pkg::SUM_W-1] ? -sum_ff : sum_ff;
   assign t_mag      = ddo_pkg::CW'((mul_p + ddo_pkg::ROUND_HALF) >> ddo_pkg::SH);
   assign rot_t      = sum_ff[ddo_pkg::SUM_W-1] ? -$signed(t_mag) : $signed(t_mag);
   assign dturn      = mul_p[ddo_pkg::ANG_W-1:0];
   assign pos_sel    = axis_ff ? pos_y_ff : pos_x_ff;
   assign pos_mag    = pos_sel[ddo_pkg::POS_W-1] ? -pos_sel : pos_sel;

   assign mm_res   = acc_ff >> ddo_pkg::FRAC_BITS;
   assign mm_limit = neg_ff ? ddo_pkg::MM_NEG_LIMIT : ddo_pkg::MM_POS_LIMIT;
   assign mm_clip  = (mm_res > mm_limit) ? mm_limit : mm_res;
   assign mm_val   = neg_ff ? -mm_clip[ddo_pkg::POS_W-1:0] : mm_clip[ddo_pkg::POS_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = (req_ch.command == ddo_pkg::CMD_UPDATE) ?
                          ddo_pkg::ST_TURN : ddo_pkg::ST_MM_LO;
            end
         end
         ddo_pkg::ST_TURN:     state_in = ddo_pkg::ST_GAIN;
         ddo_pkg::ST_GAIN:     state_in = ddo_pkg::ST_ROT_LOAD;
         ddo_pkg::ST_ROT_LOAD: state_in = ddo_pkg::ST_ROT;
         ddo_pkg::ST_ROT: begin
            if (rot_last) begin
               state_in = ddo_pkg::ST_POS;
            end
         end
         ddo_pkg::ST_POS:    state_in = ddo_pkg::ST_MM_LO;
         ddo_pkg::ST_MM_LO:  state_in = ddo_pkg::ST_MM_HI;
         ddo_pkg::ST_MM_HI:  state_in = ddo_pkg::ST_MM_SUM;
         ddo_pkg::ST_MM_SUM: state_in = ddo_pkg::ST_MM_SAT;
         ddo_pkg::ST_MM_SAT: state_in = axis_ff ? ddo_pkg::ST_DEG : ddo_pkg::ST_MM_LO;
         ddo_pkg::ST_DEG:    state_in = ddo_pkg::ST_DONE;
         ddo_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ddo_pkg::ST_IDLE;
            end
         end
         default: state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rot_ctrl  = '0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ddo_pkg::ST_IDLE: req_ready = 1'b1;
         ddo_pkg::ST_TURN: begin
            mul_a = ddo_pkg::MUL_A_W'(diff_ff);
            mul_b = turn_per_tick_ff;
         end
         ddo_pkg::ST_GAIN: begin
            mul_a = travel_mag;
            mul_b = ddo_pkg::KGAIN_Q30;
         end
         ddo_pkg::ST_ROT_LOAD: rot_ctrl.load = 1'b1;
         ddo_pkg::ST_ROT:      rot_ctrl.run = 1'b1;
         ddo_pkg::ST_MM_LO: begin
            mul_a = ddo_pkg::MUL_A_W'(pos_mag[ddo_pkg::MM_SPLIT-1:0]);
            mul_b = mm_per_tick_ff;
         end
         ddo_pkg::ST_MM_HI: begin
            mul_a = ddo_pkg::MUL_A_W'(pos_mag[ddo_pkg::POS_W-1:ddo_pkg::MM_SPLIT]);
            mul_b = mm_per_tick_ff;
         end
         ddo_pkg::ST_DEG: begin
            mul_a = ddo_pkg::MUL_A_W'(heading_ff);
            mul_b = ddo_pkg::DEG_SCALE;
         end
         ddo_pkg::ST_DONE: begin
            mul_a    = ddo_pkg::MUL_A_W'(heading_ff);
            mul_b    = ddo_pkg::DEG_SCALE;
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      start_heading_in = start_heading_ff;
      turn_per_tick_in = turn_per_tick_ff;
      mm_per_tick_in   = mm_per_tick_ff;
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      heading_in       = heading_ff;
      prev_left_in     = prev_left_ff;
      prev_right_in    = prev_right_ff;
      diff_in          = diff_ff;
      sum_in           = sum_ff;
      mid_in           = mid_ff;
      axis_in          = axis_ff;
      neg_in           = neg_ff;
      acc_in           = acc_ff;
      x_mm_in          = x_mm_ff;
      y_mm_in          = y_mm_ff;

      if (csr_write_enable) begin
         case (csr_index)
            ddo_pkg::REG_START_X:       start_x_in       = csr_write_data;
            ddo_pkg::REG_START_Y:       start_y_in       = csr_write_data;
            ddo_pkg::REG_START_HEADING: start_heading_in = csr_write_data;
            ddo_pkg::REG_TURN_PER_TICK: turn_per_tick_in = csr_write_data;
            ddo_pkg::REG_MM_PER_TICK:   mm_per_tick_in   = csr_write_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            if (req_xfer) begin
               prev_left_in  = $unsigned(req_ch.left_count);
               prev_right_in = $unsigned(req_ch.right_count);
               diff_in       = delta_r - delta_l;
               sum_in        = ddo_pkg::SUM_W'($signed(delta_l))
                             + ddo_pkg::SUM_W'($signed(delta_r));
               axis_in       = 1'b0;
               if (req_ch.command == ddo_pkg::CMD_INIT) begin
                  pos_x_in   = ddo_pkg::POS_W'($signed(start_x_ff)) << ddo_pkg::FRAC_BITS;
                  pos_y_in   = ddo_pkg::POS_W'($signed(start_y_ff)) << ddo_pkg::FRAC_BITS;
                  heading_in = start_heading_ff;
               end
            end
         end
         ddo_pkg::ST_GAIN: begin
            // midpoint heading from the old heading and half the turn
            mid_in     = heading_ff + $unsigned($signed(dturn) >>> 1);
            heading_in = heading_ff + dturn;
         end
         ddo_pkg::ST_POS: begin
            pos_x_in = pos_x_ff + $unsigned(ddo_pkg::POS_W'(rot_x));
            pos_y_in = pos_y_ff + $unsigned(ddo_pkg::POS_W'(rot_y));
            axis_in  = 1'b0;
         end
         ddo_pkg::ST_MM_LO: neg_in = pos_sel[ddo_pkg::POS_W-1];
         ddo_pkg::ST_MM_HI: acc_in = ddo_pkg::ACC_W'(mul_p);
         ddo_pkg::ST_MM_SUM: begin
            acc_in = acc_ff + (ddo_pkg::ACC_W'(mul_p) << ddo_pkg::MM_SPLIT);
         end
         ddo_pkg::ST_MM_SAT: begin
            if (axis_ff) begin
               y_mm_in = mm_val;
            end else begin
               x_mm_in = mm_val;
            end
            axis_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ddo_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
         turn_per_tick_ff <= '0;
         mm_per_tick_ff   <= ddo_pkg::MM_PER_TICK_RESET;
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         heading_ff       <= '0;
         prev_left_ff     <= '0;
         prev_right_ff    <= '0;
         axis_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         start_heading_ff <= start_heading_in;
         turn_per_tick_ff <= turn_per_tick_in;
         mm_per_tick_ff   <= mm_per_tick_in;
         pos_x_ff         <= pos_x_in;
         pos_y_ff         <= pos_y_in;
         heading_ff       <= heading_in;
         prev_left_ff     <= prev_left_in;
         prev_right_ff    <= prev_right_in;
         axis_ff          <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sum_ff  <= sum_in;
      mid_ff  <= mid_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      x_mm_ff <= x_mm_in;
      y_mm_ff <= y_mm_in;
      if (rsp_load) begin
         rsp_raw_x_ff       <= pos_x_ff;
         rsp_raw_y_ff       <= pos_y_ff;
         rsp_raw_heading_ff <= heading_ff;
         rsp_x_mm_ff        <= x_mm_ff;
         rsp_y_mm_ff        <= y_mm_ff;
         rsp_heading_deg_ff <= mul_p[ddo_pkg::DEG_SHIFT +: ddo_pkg::DEG_W];
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.raw_x       = $signed(rsp_raw_x_ff);
   assign rsp_ch.raw_y       = $signed(rsp_raw_y_ff);
   assign rsp_ch.raw_heading = rsp_raw_heading_ff;
   assign rsp_ch.x_mm        = $signed(rsp_x_mm_ff);
   assign rsp_ch.y_mm        = $signed(rsp_y_mm_ff);
   assign rsp_ch.heading_deg = rsp_heading_deg_ff;

endmodule

// ----- sv/ddo_checker.sv -----
`include "diff_drive_odometry_defines.svh"

module ddo_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ddo_pkg::POS_W-1:0]   rsp_raw_x,
   input logic [ddo_pkg::ANG_W-1:0]   rsp_raw_heading,
   input logic [ddo_pkg::DEG_W-1:0]   rsp_heading_deg
);

   // stalled result stays put
   `DDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_raw_x) && $stable(rsp_raw_heading), "result changed while stalled")

   // one request in flight at a time
   `DDO_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // a new result only appears at the end of a busy spell
   `DDO_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "result without a request in flight")

   // degrees stay under a full turn
   `DDO_ASSERT_NOW(a_deg_range, clock, reset, rsp_valid, rsp_heading_deg < ddo_pkg::DEG_LIMIT, "heading in degrees out of range")

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_raw_x       (rsp_ch.raw_x),
   .rsp_raw_heading (rsp_ch.raw_heading),
   .rsp_heading_deg (rsp_ch.heading_deg)
);
